// ----- rtl/core/ihsp_pkg.sv -----
// package for the image header size parser
// shared constants, result format codes, result struct and a marker byte helper
// no dependencies
`default_nettype none

package ihsp_pkg;

  // default width of the byte position and segment start counters
  localparam int unsigned POS_WIDTH_DEF = 32;

  // jpeg segment marker lead byte
  localparam logic [7:0] MARKER_LEAD = 8'hFF;

  // result format codes
  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_GIF  = 2'd2,
    FMT_PNG  = 2'd3
  } fmt_e;

  // one result item
  typedef struct packed {
    fmt_e        code;
    logic [31:0] width;
    logic [31:0] height;
  } res_t;

  // file signatures
  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] PNG_IHDR [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
  localparam logic [7:0] JPEG_HEAD [4] = '{8'hFF, 8'hD8, 8'hFF, 8'hE0};
  localparam logic [7:0] JFIF_TAG [4] = '{8'h4A, 8'h46, 8'h49, 8'h46};
  localparam logic [7:0] GIF_TAG [4] = '{8'h47, 8'h49, 8'h46, 8'h00};

  // start of frame markers: C0-C3 and C9-CB
  function automatic logic is_sof(input logic [7:0] m);
    is_sof = ((m >= 8'hC0) && (m <= 8'hC3)) || ((m >= 8'hC9) && (m <= 8'hCB));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ihsp_in_stage.sv -----
// input register of the image header size parser
// holds one accepted byte item until the parser takes it; uses ihsp_pkg
`default_nettype none

module ihsp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       take_i,
  output logic            item_valid_o,
  output logic [7:0]      item_byte_o,
  output logic            item_last_o
);
  import ihsp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       accept;

  // free slot or slot drained this cycle
  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;
  assign item_last_o  = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/ihsp_parser.sv -----
// parse state and per-byte update logic of the image header size parser
// tracks signatures, walks jpeg segments, collects dimensions; uses ihsp_pkg
`default_nettype none

module ihsp_parser #(
  parameter int unsigned POS_WIDTH = ihsp_pkg::POS_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            res_valid_o,
  output ihsp_pkg::res_t  res_o
);
  import ihsp_pkg::*;

  localparam int unsigned SUM_W = POS_WIDTH + 17;

  typedef logic [POS_WIDTH-1:0] pos_t;

  pos_t        pos_q, pos_d;
  pos_t        seg_q, seg_d;
  logic        jpeg_ok_q, jpeg_ok_d;
  logic        gif_ok_q, gif_ok_d;
  logic        png_ok_q, png_ok_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic        sof_seen_q, sof_seen_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic        sent_q, sent_d;

  pos_t        seg_off;
  logic        in_seg;
  logic [16:0] seg_step;
  logic [SUM_W-1:0] seg_sum;
  logic        seg_ovf;
  logic        res_valid;
  res_t        res;

  // distance into the current segment and next segment start
  assign in_seg   = (pos_q >= seg_q);
  assign seg_off  = pos_q - seg_q;
  assign seg_step = {1'b0, len_hi_q, byte_i} + 17'd2;
  assign seg_sum  = SUM_W'(seg_q) + SUM_W'(seg_step);
  assign seg_ovf  = |seg_sum[SUM_W-1:POS_WIDTH];

  // next state and result for the byte in the input register
  always_comb begin
    pos_d      = pos_q;
    seg_d      = seg_q;
    jpeg_ok_d  = jpeg_ok_q;
    gif_ok_d   = gif_ok_q;
    png_ok_d   = png_ok_q;
    len_hi_d   = len_hi_q;
    sof_seen_d = sof_seen_q;
    width_d    = width_q;
    height_d   = height_q;
    sent_d     = sent_q;
    res_valid  = 1'b0;
    res.code   = FMT_NONE;
    res.width  = 32'd0;
    res.height = 32'd0;

    // signature checks
    if (pos_q < pos_t'(4) && byte_i != JPEG_HEAD[pos_q[1:0]]) begin
      jpeg_ok_d = 1'b0;
    end
    if (pos_q >= pos_t'(6) && pos_q < pos_t'(10) &&
        byte_i != JFIF_TAG[pos_q[1:0] - 2'd2]) begin
      jpeg_ok_d = 1'b0;
    end
    if (pos_q < pos_t'(3) && byte_i != GIF_TAG[pos_q[1:0]]) begin
      gif_ok_d = 1'b0;
    end
    if (pos_q < pos_t'(8) && byte_i != PNG_SIG[pos_q[2:0]]) begin
      png_ok_d = 1'b0;
    end
    if (pos_q >= pos_t'(12) && pos_q < pos_t'(16) &&
        byte_i != PNG_IHDR[pos_q[1:0]]) begin
      png_ok_d = 1'b0;
    end

    // gif little endian words
    if (gif_ok_d) begin
      if (pos_q == pos_t'(6)) width_d = {16'd0, width_d[15:8], byte_i};
      if (pos_q == pos_t'(7)) width_d = {16'd0, byte_i, width_d[7:0]};
      if (pos_q == pos_t'(8)) height_d = {16'd0, height_d[15:8], byte_i};
      if (pos_q == pos_t'(9)) height_d = {16'd0, byte_i, height_d[7:0]};
    end

    // png big endian ihdr words
    if (png_ok_d) begin
      if (pos_q >= pos_t'(16) && pos_q < pos_t'(20)) width_d = {width_d[23:0], byte_i};
      if (pos_q >= pos_t'(20) && pos_q < pos_t'(24)) height_d = {height_d[23:0], byte_i};
    end

    // jpeg segment walk
    if (jpeg_ok_d && in_seg) begin
      if (sof_seen_q) begin
        if (seg_off == pos_t'(5)) height_d = {16'd0, byte_i, 8'd0};
        if (seg_off == pos_t'(6)) height_d = height_d | {24'd0, byte_i};
        if (seg_off == pos_t'(7)) width_d = {16'd0, byte_i, 8'd0};
        if (seg_off == pos_t'(8)) width_d = width_d | {24'd0, byte_i};
      end else if (seg_off == pos_t'(0)) begin
        if (byte_i != MARKER_LEAD) jpeg_ok_d = 1'b0;
      end else if (seg_off == pos_t'(1)) begin
        if (is_sof(byte_i)) sof_seen_d = 1'b1;
      end else if (seg_off == pos_t'(2)) begin
        len_hi_d = byte_i;
      end else if (seg_off == pos_t'(3)) begin
        if (seg_step < 17'd4 || seg_ovf) begin
          jpeg_ok_d = 1'b0;
        end else begin
          seg_d = seg_sum[POS_WIDTH-1:0];
        end
      end
    end

    // result decision
    if (!sent_q) begin
      if (pos_q == pos_t'(23) && gif_ok_d) begin
        res.code = FMT_GIF;
      end else if (pos_q == pos_t'(23) && png_ok_d) begin
        res.code = FMT_PNG;
      end else if (jpeg_ok_d && sof_seen_d && in_seg && seg_off >= pos_t'(11) &&
                   pos_q >= pos_t'(23)) begin
        res.code = FMT_JPEG;
      end
      if (res.code != FMT_NONE) begin
        res.width  = width_d;
        res.height = height_d;
        res_valid  = 1'b1;
        sent_d     = 1'b1;
      end else if (last_i) begin
        res_valid = 1'b1;
      end
    end

    // position advance, or re-arm after the last byte
    if (last_i) begin
      pos_d      = '0;
      seg_d      = pos_t'(2);
      jpeg_ok_d  = 1'b1;
      gif_ok_d   = 1'b1;
      png_ok_d   = 1'b1;
      len_hi_d   = 8'd0;
      sof_seen_d = 1'b0;
      width_d    = 32'd0;
      height_d   = 32'd0;
      sent_d     = 1'b0;
    end else if (pos_q != '1) begin
      pos_d = pos_q + pos_t'(1);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      seg_q      <= pos_t'(2);
      jpeg_ok_q  <= 1'b1;
      gif_ok_q   <= 1'b1;
      png_ok_q   <= 1'b1;
      len_hi_q   <= 8'd0;
      sof_seen_q <= 1'b0;
      width_q    <= 32'd0;
      height_q   <= 32'd0;
      sent_q     <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      seg_q      <= seg_d;
      jpeg_ok_q  <= jpeg_ok_d;
      gif_ok_q   <= gif_ok_d;
      png_ok_q   <= png_ok_d;
      len_hi_q   <= len_hi_d;
      sof_seen_q <= sof_seen_d;
      width_q    <= width_d;
      height_q   <= height_d;
      sent_q     <= sent_d;
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_o       = res;

endmodule

`default_nettype wire

// ----- rtl/core/ihsp_out_stage.sv -----
// result register of the image header size parser
// holds one result item until the consumer takes it; uses ihsp_pkg
`default_nettype none

module ihsp_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire ihsp_pkg::res_t res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ihsp_pkg::res_t      res_o
);
  import ihsp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // empty, or the held item leaves this cycle
  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/image_header_size_parser_core.sv -----
// top level of the image header size parser
// input register, parser state and update logic, result register; uses ihsp_pkg
`default_nettype none

// Takes an image file one byte item per cycle (last_byte_i marks the final
// byte) and returns one result item per file: the format (JFIF JPEG, GIF or
// PNG) with width and height, or a failure code with zero dimensions. A byte
// item is accepted every cycle while the result side keeps up. A byte is
// held in the input register; the result it completes is loaded into the
// result register as that byte steps into the parser. While a result waits
// to be taken the parser holds, and the input register takes at most one
// more byte until the result leaves. After the last byte the parser re-arms
// for the next file. POS_WIDTH sets the byte position counter, which
// saturates on very long files.
module image_header_size_parser_core #(
  parameter int unsigned POS_WIDTH = ihsp_pkg::POS_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       format_code_o,
  output logic [31:0]      width_o,
  output logic [31:0]      height_o
);
  import ihsp_pkg::*;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_last;
  logic       step;
  logic       room;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // a byte moves into the parser when the result register has room
  assign step = item_valid && room;

  ihsp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte),
    .item_last_o  (item_last)
  );

  ihsp_parser #(
    .POS_WIDTH (POS_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (item_byte),
    .last_i      (item_last),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihsp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign format_code_o = out_res.code;
  assign width_o       = out_res.width;
  assign height_o      = out_res.height;

endmodule

`default_nettype wire
